FILE: design/csms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csms_pkg;

	localparam int CAPACITY = 64;
	localparam int NCH      = 3;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int SUM_W    = $clog2(CAPACITY * 255 + 1);
	localparam int SQ_W     = $clog2(CAPACITY * 65025 + 1);
	// n * sumsq and sum^2 both fit here
	localparam int D_W      = CNT_W + SQ_W;
	localparam int R_W      = (D_W + 1) / 2;
	localparam int IT_W     = $clog2(R_W + 1);

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} csms_status_t;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} csms_action_t;

	typedef struct packed {
		logic [7:0] mean;
		logic [6:0] dev;
	} csms_res_t;

endpackage
`default_nettype wire

FILE: design/csms_div.sv
`timescale 1ns / 1ps
`default_nettype none
module csms_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [csms_pkg::R_W-1:0]     dividend,
	input  wire [csms_pkg::CNT_W-1:0]   divisor,
	output logic                        busy,
	output logic [csms_pkg::R_W-1:0]    quo
);
	import csms_pkg::*;

	logic               busy_q;
	logic [IT_W-1:0]    cnt_q;
	logic [R_W-1:0]     quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [CNT_W:0]     trial;
	logic               ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[R_W-1]};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= IT_W'(R_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != IT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[R_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: design/csms_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module csms_lane (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [csms_pkg::CNT_W-1:0]   n,
	input  wire [csms_pkg::SUM_W-1:0]   sum,
	input  wire [csms_pkg::SQ_W-1:0]    sqsum,
	output logic                        done,
	output csms_pkg::csms_res_t         res
);
	import csms_pkg::*;

	typedef enum logic [5:0] {
		L_IDLE = 6'b000001,
		L_MUL  = 6'b000010,
		L_SUB  = 6'b000100,
		L_SQRT = 6'b001000,
		L_DIV  = 6'b010000,
		L_DONE = 6'b100000
	} lane_state_t;

	lane_state_t        state_q;
	logic [CNT_W-1:0]   n_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [D_W-1:0]     a_s1;
	logic [D_W-1:0]     b_s1;
	logic [2*R_W-1:0]   x_q;
	logic [R_W:0]       rem_q;
	logic [R_W-1:0]     root_q;
	logic [IT_W-1:0]    it_q;
	logic [7:0]         mean_q;
	logic [6:0]         dev_q;

	logic [2*SUM_W-1:0] sum_sqr;
	logic [D_W-1:0]     diff;
	logic [R_W+2:0]     rem_sh;
	logic [R_W+2:0]     trial;
	logic               ge;
	logic [R_W-1:0]     root_nx;
	logic               can_start;
	logic               div_start;
	logic [R_W-1:0]     div_dividend;
	logic               div_busy;
	logic [R_W-1:0]     div_quo;

	always_comb begin
		sum_sqr = sum_q * sum_q;
		diff    = (a_s1 >= b_s1) ? (a_s1 - b_s1) : '0;
		// digit-by-digit square root, one root bit per cycle
		rem_sh  = {rem_q, x_q[2*R_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		ge      = (rem_sh >= trial);
		root_nx = {root_q[R_W-2:0], ge};
	end

	assign can_start = (state_q == L_IDLE) || (state_q == L_DONE);

	// mean division overlaps the multiply and root steps
	assign div_start    = (can_start && start) || (state_q == L_SQRT && it_q == '0);
	assign div_dividend = can_start ? R_W'(sum) : root_nx;

	csms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (can_start ? n : n_q),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			it_q    <= '0;
		end else begin
			case (state_q)
				L_IDLE: if (start) state_q <= L_MUL;
				L_MUL:  state_q <= L_SUB;
				L_SUB: begin
					state_q <= L_SQRT;
					it_q    <= IT_W'(R_W - 1);
				end
				L_SQRT: begin
					it_q <= it_q - 1'b1;
					if (it_q == '0) state_q <= L_DIV;
				end
				L_DIV:  if (!div_busy) state_q <= L_DONE;
				L_DONE: if (start) state_q <= L_MUL;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (can_start && start) begin
			n_q   <= n;
			sum_q <= sum;
			sq_q  <= sqsum;
		end
		if (state_q == L_MUL) begin
			a_s1 <= D_W'(n_q) * D_W'(sq_q);
			b_s1 <= D_W'(sum_sqr);
		end
		if (state_q == L_SUB) begin
			x_q    <= (2*R_W)'(diff);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == L_SQRT) begin
			x_q    <= {x_q[2*R_W-3:0], 2'b00};
			rem_q  <= ge ? (R_W+1)'(rem_sh - trial) : (R_W+1)'(rem_sh);
			root_q <= root_nx;
			if (it_q == '0) mean_q <= 8'(div_quo);
		end
		if (state_q == L_DIV && !div_busy) dev_q <= 7'(div_quo);
	end

	// done drops at start, so a restart from L_DONE is seen
	assign done     = (state_q == L_DONE) && !start;
	assign res.mean = (n_q == '0) ? 8'd0 : mean_q;
	assign res.dev  = (n_q == '0) ? 7'd0 : dev_q;

endmodule
`default_nettype wire

FILE: design/color_sample_mean_std_stack_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// color sample stack with per-channel mean and population deviation
//
// input channel: in_valid / in_stall carry one word (action plus a
// three-channel sample). action push stores the sample, pop drops the
// newest one. in_stall is high while a word is being worked on, so one
// word is in flight at a time.
// output channel: out_valid / out_stall carry one result word per input
// word: count, status and per channel the truncated mean and deviation.
// a pop reads the stack before the lanes start, a push does not; the
// lanes are paced by the 15-step square root and the 15-step divider
// inside each channel lane; the three lanes run side by side. a new word
// is taken only once the previous result has moved to the output register.
// a finished result sits in the output register; the next word is taken
// while it waits. if the receiver stalls longer than a full computation
// the block holds its next result until the register frees up.
// reset clears the count, the sums and all valid state; the stack
// memory is not cleared, only written entries are ever used.
module color_sample_mean_std_stack_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        action,
	input  wire  [7:0] sample_c0,
	input  wire  [7:0] sample_c1,
	input  wire  [7:0] sample_c2,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] mean_c0,
	output logic [7:0] mean_c1,
	output logic [7:0] mean_c2,
	output logic [6:0] dev_c0,
	output logic [6:0] dev_c1,
	output logic [6:0] dev_c2,
	output logic [6:0] count,
	output logic [1:0] status
);
	import csms_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_POP   = 6'b000100,
		S_START = 6'b001000,
		S_CALC  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q [NCH];
	logic [SQ_W-1:0]    sq_q  [NCH];
	csms_status_t       status_q;

	// stack storage, one sample per entry
	logic [23:0]        mem [CAPACITY];
	logic [23:0]        rd_q;
	logic               wr_en;

	logic [7:0]         in_ch [NCH];
	logic [7:0]         pop_ch [NCH];
	logic               in_acc;
	logic               lane_start;
	logic [NCH-1:0]     lane_done;
	csms_res_t          lane_res [NCH];

	logic               out_valid_q;
	csms_res_t          out_res_q [NCH];
	logic [CNT_W-1:0]   out_count_q;
	csms_status_t       out_status_q;
	logic               out_load;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign lane_start = (state_q == S_START);
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	assign in_ch[0] = sample_c0;
	assign in_ch[1] = sample_c1;
	assign in_ch[2] = sample_c2;
	assign pop_ch[0] = rd_q[7:0];
	assign pop_ch[1] = rd_q[15:8];
	assign pop_ch[2] = rd_q[23:16];

	assign wr_en = in_acc && (action == ACT_PUSH) && (count_q != CNT_W'(CAPACITY));

	// write on push, registered read of the entry at the count
	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[ADDR_W-1:0]] <= {sample_c2, sample_c1, sample_c0};
		rd_q <= mem[count_q[ADDR_W-1:0]];
	end

	// sequencer and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_OK;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
				sq_q[c]  <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == ACT_PUSH) begin
							state_q <= S_START;
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_PUSH_FULL;
							end else begin
								status_q <= ST_OK;
								count_q  <= count_q + 1'b1;
								for (int c = 0; c < NCH; c++) begin
									sum_q[c] <= sum_q[c] + SUM_W'(in_ch[c]);
									sq_q[c]  <= sq_q[c] +
										SQ_W'(16'(in_ch[c]) * 16'(in_ch[c]));
								end
							end
						end else if (count_q == '0) begin
							status_q <= ST_POP_EMPTY;
							state_q  <= S_START;
						end else begin
							// address follows the decremented count
							status_q <= ST_OK;
							count_q  <= count_q - 1'b1;
							state_q  <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_POP;
				S_POP: begin
					for (int c = 0; c < NCH; c++) begin
						sum_q[c] <= sum_q[c] - SUM_W'(pop_ch[c]);
						sq_q[c]  <= sq_q[c] - SQ_W'(16'(pop_ch[c]) * 16'(pop_ch[c]));
					end
					state_q <= S_START;
				end
				S_START: state_q <= S_CALC;
				S_CALC:  if (&lane_done) state_q <= S_OUT;
				S_OUT:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// one lane per color channel
	for (genvar g = 0; g < NCH; g++) begin : g_lane
		csms_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.n      (count_q),
			.sum    (sum_q[g]),
			.sqsum  (sq_q[g]),
			.done   (lane_done[g]),
			.res    (lane_res[g])
		);
	end

	// merge stage: gather lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int c = 0; c < NCH; c++) out_res_q[c] <= lane_res[c];
			out_count_q  <= count_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_c0   = out_res_q[0].mean;
	assign mean_c1   = out_res_q[1].mean;
	assign mean_c2   = out_res_q[2].mean;
	assign dev_c0    = out_res_q[0].dev;
	assign dev_c1    = out_res_q[1].dev;
	assign dev_c2    = out_res_q[2].dev;
	assign count     = 7'(out_count_q);
	assign status    = out_status_q;

endmodule
`default_nettype wire

FILE: design/csms_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module csms_chk (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       action,
	input wire [7:0] sample_c0,
	input wire [7:0] sample_c1,
	input wire [7:0] sample_c2,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] mean_c0,
	input wire [7:0] mean_c1,
	input wire [7:0] mean_c2,
	input wire [6:0] dev_c0,
	input wire [6:0] dev_c1,
	input wire [6:0] dev_c2,
	input wire [6:0] count,
	input wire [1:0] status
);
	import csms_pkg::*;

	// a taken word keeps the input side busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(count) && $stable(status)))
		else $error("stalled result changed");

	// empty set reports zero statistics
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count == 7'd0) |->
		(mean_c0 == 8'd0 && mean_c1 == 8'd0 && mean_c2 == 8'd0 &&
		 dev_c0 == 7'd0 && dev_c1 == 7'd0 && dev_c2 == 7'd0))
		else $error("nonzero statistics on empty set");

	// dropped push only when full, ignored pop only when empty
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		((status == ST_OK) ||
		 (status == ST_PUSH_FULL && count == 7'(CAPACITY)) ||
		 (status == ST_POP_EMPTY && count == 7'd0)))
		else $error("status does not match count");

endmodule

bind color_sample_mean_std_stack_unit csms_chk u_csms_chk (.*);
`default_nettype wire

FILE: tb/color_sample_mean_std_stack_unit_test.sv
`timescale 1ns / 1ps
module color_sample_mean_std_stack_unit_test;
	import csms_pkg::*;

	// expected result of one word
	typedef struct {
		logic [7:0] mean [3];
		logic [6:0] dev [3];
		logic [6:0] cnt;
		csms_status_t st;
	} stat_word_t;

	// running statistics of the held samples, plus the queue of expected words
	class stack_stats_board;
		logic [23:0] held [CAPACITY];
		int unsigned depth;
		longint unsigned sum [3];
		longint unsigned sqsum [3];
		stat_word_t pending [$];
		int errors;
		int checked;

		function new();
			depth = 0;
			errors = 0;
			checked = 0;
			for (int c = 0; c < 3; c++) begin
				sum[c] = 0;
				sqsum[c] = 0;
			end
		endfunction

		// bitwise integer square root, floor
		function longint unsigned isqrt(longint unsigned x);
			longint unsigned r;
			r = 0;
			for (int b = 31; b >= 0; b--)
				if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x)
					r = r | (64'd1 << b);
			return r;
		endfunction

		// apply one accepted word and queue its expected statistics
		function void note_word(logic act, logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
			stat_word_t w;
			logic [7:0] smp [3];
			longint unsigned a, b, d;
			smp[0] = s0;
			smp[1] = s1;
			smp[2] = s2;
			w.st = ST_OK;
			if (act == ACT_PUSH) begin
				if (depth >= CAPACITY) w.st = ST_PUSH_FULL;
				else begin
					held[depth] = {s2, s1, s0};
					depth++;
					for (int c = 0; c < 3; c++) begin
						sum[c] += 64'(smp[c]);
						sqsum[c] += 64'(smp[c]) * 64'(smp[c]);
					end
				end
			end else begin
				if (depth == 0) w.st = ST_POP_EMPTY;
				else begin
					depth--;
					for (int c = 0; c < 3; c++) begin
						smp[c] = held[depth][8*c +: 8];
						sum[c] -= 64'(smp[c]);
						sqsum[c] -= 64'(smp[c]) * 64'(smp[c]);
					end
				end
			end
			for (int c = 0; c < 3; c++) begin
				w.mean[c] = '0;
				w.dev[c] = '0;
				if (depth != 0) begin
					a = depth * sqsum[c];
					b = sum[c] * sum[c];
					d = (a >= b) ? a - b : 0;
					w.mean[c] = 8'(sum[c] / depth);
					w.dev[c] = 7'(isqrt(d) / depth);
				end
			end
			w.cnt = 7'(depth);
			pending = {pending, w};
		endfunction

		// compare one result word against the oldest expectation
		function void check_word(logic [7:0] m [3], logic [6:0] dv [3], logic [6:0] cnt,
				logic [1:0] st);
			stat_word_t w;
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			w = pending.pop_front();
			checked++;
			for (int c = 0; c < 3; c++) begin
				if (m[c] !== w.mean[c]) begin
					$error("mean_c%0d expected %0d got %0d", c, w.mean[c], m[c]);
					errors++;
				end
				if (dv[c] !== w.dev[c]) begin
					$error("dev_c%0d expected %0d got %0d", c, w.dev[c], dv[c]);
					errors++;
				end
			end
			if (cnt !== w.cnt) begin
				$error("count expected %0d got %0d", w.cnt, cnt);
				errors++;
			end
			if (st !== w.st) begin
				$error("status expected %0d got %0d", w.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic action = 0;
	logic [7:0] sample_c0 = 0, sample_c1 = 0, sample_c2 = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] mean_c0, mean_c1, mean_c2;
	logic [6:0] dev_c0, dev_c1, dev_c2;
	logic [6:0] count;
	logic [1:0] status;

	stack_stats_board board = new();
	int idle_cycles = 0;
	int pushes = 0, pops = 0, full_hits = 0, empty_hits = 0;
	bit stall_mode = 0;

	always #5 clk = ~clk;

	color_sample_mean_std_stack_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .sample_c0(sample_c0), .sample_c1(sample_c1),
		.sample_c2(sample_c2),
		.out_valid(out_valid), .out_stall(out_stall),
		.mean_c0(mean_c0), .mean_c1(mean_c1), .mean_c2(mean_c2),
		.dev_c0(dev_c0), .dev_c1(dev_c1), .dev_c2(dev_c2),
		.count(count), .status(status)
	);

	// sample both channels at the rising edge; the watchdog counts quiet cycles
	always @(posedge clk) begin
		logic [7:0] m [3];
		logic [6:0] dv [3];
		bit moved;
		moved = 0;
		if (arst_n && in_valid && !in_stall) begin
			board.note_word(action, sample_c0, sample_c1, sample_c2);
			moved = 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			m[0] = mean_c0;
			m[1] = mean_c1;
			m[2] = mean_c2;
			dv[0] = dev_c0;
			dv[1] = dev_c1;
			dv[2] = dev_c2;
			board.check_word(m, dv, count, status);
			if (status == ST_PUSH_FULL) full_hits++;
			if (status == ST_POP_EMPTY) empty_hits++;
			moved = 1;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("timeout with %0d words outstanding", board.pending.size());
			$display("color_sample_mean_std_stack_unit_test: FAIL");
			$finish;
		end
	end

	// receiver stall: phases of no stall and phases of heavy random stall
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
		if (!stall_mode) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 99) < 70);
	end

	// present one word and hold it until accepted
	task automatic send_word(logic act, logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
		in_valid <= 1;
		action <= act;
		sample_c0 <= s0;
		sample_c1 <= s1;
		sample_c2 <= s2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (act == ACT_PUSH) pushes++;
		else pops++;
	endtask

	// gap between bursts with valid low
	task automatic gap(int n);
		in_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	// fill toward full or empty with well-formed sequences, random content
	task automatic random_burst(int len, int push_pct);
		for (int i = 0; i < len; i++) begin
			logic act;
			act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
			case ($urandom_range(0, 3))
				0: send_word(act, 8'hFF, 8'($urandom_range(0, 255)), 8'h00);
				default: send_word(act, 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	initial begin
		int sent;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty pops, extremes, fill past full, empty again
		send_word(ACT_POP, 8'h00, 8'h00, 8'h00);
		send_word(ACT_PUSH, 8'hFF, 8'hFF, 8'hFF);
		send_word(ACT_PUSH, 8'h00, 8'h00, 8'h00);
		send_word(ACT_PUSH, 8'hAA, 8'h55, 8'h01);
		send_word(ACT_POP, 8'hFF, 8'hFF, 8'hFF);
		send_word(ACT_POP, 8'h00, 8'h00, 8'h00);
		send_word(ACT_POP, 8'h00, 8'h00, 8'h00);
		send_word(ACT_POP, 8'h12, 8'h34, 8'h56);
		sent = 8;
		// pause until all results are back
		drain();
		// alternating extremes up to full give the largest deviation
		for (int i = 0; i < CAPACITY + 2; i++) begin
			logic [7:0] v;
			v = i[0] ? 8'hFF : 8'h00;
			send_word(ACT_PUSH, v, ~v, v);
		end
		sent += CAPACITY + 2;
		for (int i = 0; i < CAPACITY + 1; i++) send_word(ACT_POP, 8'h00, 8'h00, 8'h00);
		sent += CAPACITY + 1;

		// random bursts drifting between full and empty
		while (sent < 1950) begin
			int len;
			int bias;
			len = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: bias = 85;
				1: bias = 15;
				default: bias = 55;
			endcase
			random_burst(len, bias);
			sent += len;
			if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 60));
			if ($urandom_range(0, 49) == 0) drain();
		end

		drain();
		repeat (100) @(negedge clk);
		$display("sent %0d pushes and %0d pops, checked %0d result words", pushes, pops,
			board.checked);
		$display("full-stack pushes seen %0d, empty-stack pops seen %0d", full_hits,
			empty_hits);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("color_sample_mean_std_stack_unit_test: PASS");
		else
			$display("color_sample_mean_std_stack_unit_test: FAIL");
		$finish;
	end

endmodule
